// ===== hdl/response_packet_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Response packet deframer assertion macros
// Concurrent assertion shorthands for the deframer checker in rpd_checker.sv.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_PACKET_DEFRAMER_DEFINES_SVH
`define RESPONSE_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define RPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define RPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== hdl/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Response packet deframer package
// Codes, header constants and the result record shared by the deframer files.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam logic [7:0]  HDR_FIRST  = 8'hEF;
   localparam logic [7:0]  HDR_SECOND = 8'h01;
   localparam logic [9:0]  ADDR_BYTES = 10'd4;
   localparam logic [15:0] LEN_MIN    = 16'd3;
   localparam int          IDX_W      = 10;
   localparam int          RSP_DATA_W = 32;

   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_TIMEOUT = 1'b1
   } op_type;

   typedef enum logic {
      KIND_PARAM = 1'b0,
      KIND_END   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_CKSUM   = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_LENGTH  = 2'd3
   } status_type;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] param_index;
      logic [7:0]       param_byte;
      logic [7:0]       confirm_code;
      status_type       status;
      logic             last;
   } rsp_type;

endpackage

// ===== hdl/response_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// Response packet deframer
// Hunts for 0xEF 0x01 framed response packets in a received byte stream,
// emits each parameter byte and one end-of-packet status transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per received byte (req_tuser = 0) or per
//   byte-wait timeout (req_tuser = 1); the byte is in req_tdata.
//   rsp channel: zero or one transaction per request. rsp_tuser = 0 carries a
//   parameter byte and its index; rsp_tuser = 1 with rsp_tlast set closes the
//   packet with the confirmation code and status (ok, checksum error,
//   timeout abort, length error).
//   Output: each result is registered before it appears on rsp.
//   Throughput: one request per cycle while req_tready is high; the frame
//   state is updated in the accept cycle; that update is the only loop.
//   Stall: a two-entry output (result register plus skid register) lets one
//   more request in while a result waits; req_tready drops only while the
//   skid register is full.
//   Reset: synchronous, active high; clears frame state to the header hunt
//   and empties both output registers.
// ----------------------------------------------------------------------------
module response_packet_deframer #(
   parameter int MAX_PACKET_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [9:0] param_index, [17:10] param_byte,
                                    // [25:18] confirm_code, [27:26] status,
                                    // [31:28] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // [0] last
);

   localparam logic [15:0] MaxLen = 16'(MAX_PACKET_BYTES - 9);

   typedef enum logic [3:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_ADDR,
      PH_PID,
      PH_LENH,
      PH_LENL,
      PH_CONF,
      PH_PARAM,
      PH_CKH,
      PH_CKL
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [9:0]         cnt_ff, cnt_in;
   logic [15:0]        len_ff, len_in;
   logic [15:0]        sum_ff, sum_in;
   logic [7:0]         conf_ff, conf_in;
   logic [7:0]         ckh_ff, ckh_in;

   logic               out_valid_ff, out_valid_in;
   rpd_pkg::rsp_type   out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   rpd_pkg::rsp_type   skid_ff, skid_in;

   logic               req_fire;
   logic               res_fire;
   rpd_pkg::rsp_type   res;
   logic [7:0]         rx;
   logic [15:0]        len_full;
   logic [9:0]         cnt_next;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign len_full   = {len_ff[15:8], rx};
   assign cnt_next   = cnt_ff + 10'd1;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      conf_in  = conf_ff;
      ckh_in   = ckh_ff;
      res_fire = 1'b0;
      res      = '0;
      if (req_fire) begin
         if (rpd_pkg::op_type'(req_tuser) == rpd_pkg::OP_TIMEOUT) begin
            if (phase_ff != PH_HUNT1) begin
               res_fire         = 1'b1;
               res.kind         = rpd_pkg::KIND_END;
               res.confirm_code = conf_ff;
               res.status       = rpd_pkg::ST_TIMEOUT;
               res.last         = 1'b1;
               phase_in         = PH_HUNT1;
            end
         end else begin
            case (phase_ff)
               PH_HUNT1: begin
                  if (rx == rpd_pkg::HDR_FIRST) phase_in = PH_HUNT2;
               end
               PH_HUNT2: begin
                  if (rx == rpd_pkg::HDR_SECOND) begin
                     phase_in = PH_ADDR;
                     cnt_in   = '0;
                     conf_in  = '0;
                  end else if (rx != rpd_pkg::HDR_FIRST) begin
                     phase_in = PH_HUNT1;
                  end
               end
               PH_ADDR: begin
                  cnt_in = cnt_next;
                  if (cnt_next >= rpd_pkg::ADDR_BYTES) phase_in = PH_PID;
               end
               PH_PID: begin
                  sum_in   = {8'd0, rx};
                  phase_in = PH_LENH;
               end
               PH_LENH: begin
                  sum_in   = sum_ff + {8'd0, rx};
                  len_in   = {rx, 8'd0};
                  phase_in = PH_LENL;
               end
               PH_LENL: begin
                  sum_in = sum_ff + {8'd0, rx};
                  len_in = len_full;
                  if (len_full < rpd_pkg::LEN_MIN || len_full > MaxLen) begin
                     res_fire   = 1'b1;
                     res.kind   = rpd_pkg::KIND_END;
                     res.status = rpd_pkg::ST_LENGTH;
                     res.last   = 1'b1;
                     phase_in   = PH_HUNT1;
                  end else begin
                     phase_in = PH_CONF;
                  end
               end
               PH_CONF: begin
                  sum_in   = sum_ff + {8'd0, rx};
                  conf_in  = rx;
                  cnt_in   = '0;
                  phase_in = (len_ff == rpd_pkg::LEN_MIN) ? PH_CKH : PH_PARAM;
               end
               PH_PARAM: begin
                  sum_in           = sum_ff + {8'd0, rx};
                  res_fire         = 1'b1;
                  res.kind         = rpd_pkg::KIND_PARAM;
                  res.param_index  = cnt_ff;
                  res.param_byte   = rx;
                  res.confirm_code = conf_ff;
                  res.status       = rpd_pkg::ST_OK;
                  cnt_in           = cnt_next;
                  if ({6'd0, cnt_next} >= len_ff - rpd_pkg::LEN_MIN) phase_in = PH_CKH;
               end
               PH_CKH: begin
                  ckh_in   = rx;
                  phase_in = PH_CKL;
               end
               PH_CKL: begin
                  res_fire         = 1'b1;
                  res.kind         = rpd_pkg::KIND_END;
                  res.confirm_code = conf_ff;
                  res.status       = ({ckh_ff, rx} == sum_ff) ? rpd_pkg::ST_OK
                                                              : rpd_pkg::ST_CKSUM;
                  res.last         = 1'b1;
                  phase_in         = PH_HUNT1;
               end
               default: begin
                  phase_in = PH_HUNT1;
               end
            endcase
         end
      end
   end

   // output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_fire;
            out_in       = res;
         end
      end else if (res_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT1;
         cnt_ff        <= '0;
         len_ff        <= '0;
         sum_ff        <= '0;
         conf_ff       <= '0;
         ckh_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         len_ff        <= len_in;
         sum_ff        <= sum_in;
         conf_ff       <= conf_in;
         ckh_ff        <= ckh_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         out_ff        <= out_in;
         skid_ff       <= skid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.status, out_ff.confirm_code, out_ff.param_byte,
                        out_ff.param_index};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

endmodule

// ===== hdl/rpd_checker.sv =====
// ----------------------------------------------------------------------------
// Response packet deframer checker
// Port-level assertions on the result channel, bound into the deframer.
// ----------------------------------------------------------------------------
`include "response_packet_deframer_defines.svh"

module rpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   logic param_xact;
   logic end_xact;

   assign param_xact = rsp_tvalid && (rsp_tuser == rpd_pkg::KIND_PARAM);
   assign end_xact   = rsp_tvalid && (rsp_tuser == rpd_pkg::KIND_END);

   `RPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `RPD_ASSERT_NOW(a_param_fields, clock, reset, param_xact, !rsp_tlast && rsp_tdata[27:26] == rpd_pkg::ST_OK)
   `RPD_ASSERT_NOW(a_end_fields, clock, reset, end_xact, rsp_tlast && rsp_tdata[17:0] == 18'd0)
   `RPD_ASSERT_NOW(a_len_err_conf, clock, reset, end_xact && rsp_tdata[27:26] == rpd_pkg::ST_LENGTH, rsp_tdata[25:18] == 8'd0 && rsp_tdata[31:28] == 4'd0)

endmodule

bind response_packet_deframer rpd_checker u_rpd_checker (.*);

// ===== verif/response_packet_deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response packet deframer checker
// Watches both stream channels of the deframer and tracks the frame state
// from every accepted request. It queues the parameter byte and end-of-packet
// transactions that the block should produce and compares each accepted
// response with the oldest one, field by field.
// ----------------------------------------------------------------------------
module response_packet_deframer_checker #(
   parameter int MAX_PACKET_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          results_owed
);

   import rpd_pkg::*;

   typedef enum logic [3:0] {
      SEEK_SYNC1,
      SEEK_SYNC2,
      SKIP_ADDR,
      TAKE_PID,
      TAKE_LEN_HI,
      TAKE_LEN_LO,
      TAKE_CONFIRM,
      TAKE_PARAMS,
      TAKE_SUM_HI,
      TAKE_SUM_LO
   } frame_phase_type;

   frame_phase_type  phase_q;
   logic [IDX_W-1:0] count_q;
   logic [15:0]      len_q;
   logic [15:0]      sum_q;
   logic [7:0]       confirm_q;
   logic [7:0]       sum_hi_q;
   rsp_type          owed_q[$];
   int               mismatches;

   function automatic rsp_type make_result(input kind_type k, input logic [IDX_W-1:0] idx,
                                           input logic [7:0] pb, input logic [7:0] cc,
                                           input status_type st, input logic lst);
      rsp_type r;
      r.kind         = k;
      r.param_index  = idx;
      r.param_byte   = pb;
      r.confirm_code = cc;
      r.status       = st;
      r.last         = lst;
      return r;
   endfunction

   task automatic track_request(input op_type op, input logic [7:0] b);
      logic [15:0] got_sum;
      if (op == OP_TIMEOUT) begin
         if (phase_q != SEEK_SYNC1)
            owed_q.push_back(make_result(KIND_END, '0, 8'h00, confirm_q, ST_TIMEOUT, 1'b1));
         phase_q = SEEK_SYNC1;
         return;
      end
      case (phase_q)
         SEEK_SYNC1: begin
            if (b == HDR_FIRST)
               phase_q = SEEK_SYNC2;
         end
         SEEK_SYNC2: begin
            if (b == HDR_SECOND) begin
               phase_q   = SKIP_ADDR;
               count_q   = '0;
               confirm_q = 8'h00;
            end else if (b != HDR_FIRST) begin
               phase_q = SEEK_SYNC1;
            end
         end
         SKIP_ADDR: begin
            count_q = count_q + 1'b1;
            if (count_q >= ADDR_BYTES)
               phase_q = TAKE_PID;
         end
         TAKE_PID: begin
            sum_q   = {8'h00, b};
            phase_q = TAKE_LEN_HI;
         end
         TAKE_LEN_HI: begin
            sum_q   = sum_q + b;
            len_q   = {b, 8'h00};
            phase_q = TAKE_LEN_LO;
         end
         TAKE_LEN_LO: begin
            sum_q = sum_q + b;
            len_q = {len_q[15:8], b};
            if (len_q < LEN_MIN || int'(len_q) + 9 > MAX_PACKET_BYTES) begin
               owed_q.push_back(make_result(KIND_END, '0, 8'h00, 8'h00, ST_LENGTH, 1'b1));
               phase_q = SEEK_SYNC1;
            end else begin
               phase_q = TAKE_CONFIRM;
            end
         end
         TAKE_CONFIRM: begin
            sum_q     = sum_q + b;
            confirm_q = b;
            count_q   = '0;
            phase_q   = (len_q == LEN_MIN) ? TAKE_SUM_HI : TAKE_PARAMS;
         end
         TAKE_PARAMS: begin
            sum_q = sum_q + b;
            owed_q.push_back(make_result(KIND_PARAM, count_q, b, confirm_q, ST_OK, 1'b0));
            count_q = count_q + 1'b1;
            if (int'(count_q) >= int'(len_q) - 3)
               phase_q = TAKE_SUM_HI;
         end
         TAKE_SUM_HI: begin
            sum_hi_q = b;
            phase_q  = TAKE_SUM_LO;
         end
         TAKE_SUM_LO: begin
            got_sum = {sum_hi_q, b};
            owed_q.push_back(make_result(KIND_END, '0, 8'h00, confirm_q,
                                         (got_sum == sum_q) ? ST_OK : ST_CKSUM, 1'b1));
            phase_q = SEEK_SYNC1;
         end
         default: phase_q = SEEK_SYNC1;
      endcase
   endtask

   task automatic note_field(input string what, input int want, input int got);
      if (want != got) begin
         if (mismatches < 10)
            $display("%0t: response %s mismatch: expected 0x%0h, actual 0x%0h",
                     $realtime, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase_q    = SEEK_SYNC1;
         count_q    = '0;
         len_q      = '0;
         sum_q      = '0;
         confirm_q  = '0;
         sum_hi_q   = '0;
         mismatches = 0;
         owed_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected response: tuser=%0b tlast=%0b tdata=0x%08h",
                           $realtime, rsp_tuser, rsp_tlast, rsp_tdata);
               mismatches++;
            end else begin
               want = owed_q.pop_front();
               note_field("kind", want.kind, rsp_tuser);
               note_field("param_index", want.param_index, rsp_tdata[9:0]);
               note_field("param_byte", want.param_byte, rsp_tdata[17:10]);
               note_field("confirm_code", want.confirm_code, rsp_tdata[25:18]);
               note_field("status", want.status, rsp_tdata[27:26]);
               note_field("padding", 0, rsp_tdata[31:28]);
               note_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            track_request(op_type'(req_tuser), req_tdata);
      end
      results_owed <= owed_q.size();
      error_count  <= mismatches;
   end

endmodule

// ===== verif/tb_response_packet_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response packet deframer testbench
// Feeds received bytes and wait timeouts into the deframer: a few hand-built
// packets for the header, length, checksum and timeout cases, then mostly
// well-formed packets with random content mixed with noise, bad checksums,
// cut-off packets and out-of-range lengths. Both channels stall at random;
// the checker alongside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_response_packet_deframer;

   import rpd_pkg::*;

   localparam int MAX_PACKET_BYTES = 128;
   localparam int RANDOM_ITEMS     = 850;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          error_count;
   int          results_owed;

   logic        hold_go      = 1'b0;
   bit          hold_done    = 1'b0;
   int          hold_left    = 0;
   int          sink_cycle   = 0;
   bit          quiet_sender = 1'b0;
   int          items_sent   = 0;

   always #5 clock = ~clock;

   response_packet_deframer #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   response_packet_deframer_checker #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   // response sink: random stalls, one steady stretch, one long hold-off
   always @(posedge clock) begin
      sink_cycle++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (sink_cycle >= 400 && sink_cycle < 1400) || $urandom_range(99) >= 7;
      end
   end

   task automatic push_item(input op_type op, input logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      if (!quiet_sender && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4))
            @(posedge clock);
      end
   endtask

   // cut_at >= 0 replaces that byte of the frame by a timeout and ends it there
   task automatic send_packet(input logic [15:0] len, input bit bad_sum, input int cut_at);
      logic [7:0]  frame[$];
      logic [15:0] sum;
      logic [7:0]  pid;
      logic [7:0]  conf;
      logic [7:0]  pb;
      pid   = 8'($urandom_range(255));
      conf  = 8'($urandom_range(255));
      frame = {HDR_FIRST, HDR_SECOND};
      repeat (4)
         frame.push_back(8'($urandom_range(255)));
      frame.push_back(pid);
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
      sum = pid + len[15:8] + len[7:0];
      if (len >= LEN_MIN && int'(len) + 9 <= MAX_PACKET_BYTES) begin
         frame.push_back(conf);
         sum = sum + conf;
         for (int n = 0; n < int'(len) - 3; n++) begin
            pb = 8'($urandom_range(255));
            frame.push_back(pb);
            sum = sum + pb;
         end
         if (bad_sum)
            sum = sum ^ 16'(1 << $urandom_range(15));
         frame.push_back(sum[15:8]);
         frame.push_back(sum[7:0]);
      end
      for (int n = 0; n < frame.size(); n++) begin
         if (n == cut_at) begin
            push_item(OP_TIMEOUT, 8'($urandom_range(255)));
            return;
         end
         push_item(OP_BYTE, frame[n]);
      end
   endtask

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return 16'($urandom_range(3, 12));
      else if (r < 70)
         return 16'($urandom_range(13, MAX_PACKET_BYTES - 9));
      else if (r < 74)
         return 16'(MAX_PACKET_BYTES - 9);
      else if (r < 78)
         return 16'(MAX_PACKET_BYTES - 8);
      else if (r < 84)
         return 16'($urandom_range(0, 2));
      else if (r < 90)
         return 16'($urandom_range(16'hFFFF));
      return 16'($urandom_range(3, 6));
   endfunction

   initial begin
      int r;
      int random_base;
      repeat (7)
         @(posedge clock);
      reset <= 1'b0;

      // hunt timeout, noise, bad second header byte, repeated first header byte
      push_item(OP_TIMEOUT, 8'hFF);
      push_item(OP_BYTE, 8'h00);
      push_item(OP_BYTE, HDR_FIRST);
      push_item(OP_BYTE, 8'hFE);
      push_item(OP_BYTE, HDR_FIRST);
      send_packet(16'd2, 1'b0, -1);
      send_packet(16'd3, 1'b0, -1);
      send_packet(16'd5, 1'b1, -1);
      send_packet(16'd6, 1'b0, 9);
      send_packet(16'd4, 1'b0, 1);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);

      hold_go <= 1'b1;
      random_base = items_sent;
      while (items_sent < random_base + RANDOM_ITEMS) begin
         quiet_sender = (items_sent - random_base >= 300) && (items_sent - random_base < 500);
         r = $urandom_range(99);
         if (r < 85) begin
            send_packet(pick_length(), $urandom_range(9) == 0,
                        ($urandom_range(9) == 0) ? $urandom_range(1, 20) : -1);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               r = $urandom_range(99);
               if (r < 20)
                  push_item(OP_TIMEOUT, 8'($urandom_range(255)));
               else if (r < 40)
                  push_item(OP_BYTE, HDR_FIRST);
               else
                  push_item(OP_BYTE, 8'($urandom_range(255)));
            end
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);
      repeat (10)
         @(posedge clock);
      if (error_count == 0 && results_owed == 0)
         $display("tb_response_packet_deframer: clean");
      else
         $display("tb_response_packet_deframer: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_response_packet_deframer: errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rpd_pkg.sv
hdl/response_packet_deframer.sv
hdl/rpd_checker.sv
verif/response_packet_deframer_checker.sv
verif/tb_response_packet_deframer.sv
